/* design/caldate_pkg.sv */
// Shared types, codes and calendar helpers for the Gregorian date counter.
// Used by calendar_date_counter_core; depends on nothing else.
package caldate_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DOY_W    = 9;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	// Stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	typedef logic [YEAR_W-1:0]   year_t;
	typedef logic [MONTH_W-1:0]  month_t;
	typedef logic [DAY_W-1:0]    day_t;
	typedef logic [DOY_W-1:0]    doy_t;
	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam func_t FUNC_ADVANCE = 2'd0;
	localparam func_t FUNC_RETREAT = 2'd1;
	localparam func_t FUNC_LOAD    = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_LOAD = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;

	localparam year_t  RESET_YEAR = 14'd2000;
	localparam month_t JANUARY    = 4'd1;
	localparam month_t FEBRUARY   = 4'd2;
	localparam month_t DECEMBER   = 4'd12;
	localparam day_t   FIRST_DAY  = 5'd1;
	localparam day_t   LAST_DAY   = 5'd31;

	// Leap rule. The century count comes from a reciprocal multiply:
	// floor(y * 5243 / 2^19) equals floor(y / 100) for every 14-bit y.
	function automatic logic is_leap(input year_t y);
		logic [26:0] prod;
		logic [7:0]  cent;
		year_t       rem;
		prod = 27'(y) * 27'(5243);
		cent = prod[26:19];
		rem  = y - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
		return (y[1:0] == 2'd0) && ((rem != '0) || (cent[1:0] == 2'd0));
	endfunction

	function automatic day_t month_len(input month_t m, input logic leap);
		day_t n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic doy_t days_before(input month_t m);
		doy_t n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

/* design/calendar_date_counter_core.sv */
// Gregorian date counter: top level with input register, date state and result register.
// Depends on caldate_pkg for types, operation and status codes and calendar helpers.
//
// Holds a date (reset to 1 January 2000) and applies one operation per transaction:
// advance one day, retreat one day, or load a checked date (tuser selects which).
// Each transaction returns the resulting date, its day of year, the leap flag and a
// status. The block takes one transaction per cycle while results are taken; an
// accepted item waits in the input register and is offered once it moves to the result
// register, and the date state updates on that same edge. A stalled result holds the
// input register and, once that register is full, drops tready until the result is taken.
// Years run from 0 to MAX_YEAR; a step beyond that keeps the date and flags it.
module calendar_date_counter_core #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// new_year[13:0], new_month[17:14], new_day[22:18], zero pad
	input  logic [caldate_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[1:0]
	input  logic [caldate_pkg::FUNC_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// year[13:0], month[17:14], day[22:18], day_of_year[31:23], leap_year[32], zero pad
	output logic [caldate_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [caldate_pkg::STATUS_W-1:0]      m_tuser
);
	import caldate_pkg::*;

	localparam year_t MAX_YEAR_C = YEAR_W'(MAX_YEAR);

	// Input register
	logic    valid_s1;
	func_t   func_s1;
	year_t   new_year_s1;
	month_t  new_month_s1;
	day_t    new_day_s1;
	logic    new_leap_s1;

	// Date state
	year_t   year_q;
	month_t  month_q;
	day_t    day_q;
	logic    leap_q;

	// Result register
	logic    m_valid_q;
	year_t   res_year_q;
	month_t  res_month_q;
	day_t    res_day_q;
	doy_t    res_doy_q;
	logic    res_leap_q;
	status_t res_status_q;

	logic    out_free;
	logic    s1_ready;
	logic    advance;

	year_t   year_nx;
	month_t  month_nx;
	day_t    day_nx;
	logic    leap_nx;
	status_t status_nx;
	doy_t    doy_nx;
	logic    leap_up;
	logic    leap_dn;
	logic    load_ok;

	assign out_free = !m_valid_q || m_tready;
	assign s1_ready = !valid_s1 || out_free;
	assign s_tready = s1_ready;
	assign advance  = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_ready) begin
			func_s1      <= s_tuser;
			new_year_s1  <= s_tdata[13:0];
			new_month_s1 <= s_tdata[17:14];
			new_day_s1   <= s_tdata[22:18];
			new_leap_s1  <= is_leap(s_tdata[13:0]);
		end
	end

	assign leap_up = is_leap(year_q + YEAR_W'(1));
	assign leap_dn = is_leap(year_q - YEAR_W'(1));

	assign load_ok = (new_month_s1 >= JANUARY) && (new_month_s1 <= DECEMBER)
		&& (new_day_s1 >= FIRST_DAY)
		&& (new_day_s1 <= month_len(new_month_s1, new_leap_s1))
		&& (new_year_s1 <= MAX_YEAR_C);

	always_comb begin
		year_nx   = year_q;
		month_nx  = month_q;
		day_nx    = day_q;
		leap_nx   = leap_q;
		status_nx = ST_OK;
		unique case (func_s1)
			FUNC_ADVANCE: begin
				if ((month_q == DECEMBER) && (day_q == LAST_DAY)) begin
					if (year_q >= MAX_YEAR_C) begin
						status_nx = ST_RANGE;
					end else begin
						year_nx  = year_q + YEAR_W'(1);
						month_nx = JANUARY;
						day_nx   = FIRST_DAY;
						leap_nx  = leap_up;
					end
				end else if (day_q >= month_len(month_q, leap_q)) begin
					month_nx = month_q + MONTH_W'(1);
					day_nx   = FIRST_DAY;
				end else begin
					day_nx = day_q + DAY_W'(1);
				end
			end
			FUNC_RETREAT: begin
				if ((month_q == JANUARY) && (day_q == FIRST_DAY)) begin
					if (year_q == '0) begin
						status_nx = ST_RANGE;
					end else begin
						year_nx  = year_q - YEAR_W'(1);
						month_nx = DECEMBER;
						day_nx   = LAST_DAY;
						leap_nx  = leap_dn;
					end
				end else if (day_q <= FIRST_DAY) begin
					month_nx = month_q - MONTH_W'(1);
					day_nx   = month_len(month_q - MONTH_W'(1), leap_q);
				end else begin
					day_nx = day_q - DAY_W'(1);
				end
			end
			FUNC_LOAD: begin
				if (load_ok) begin
					year_nx  = new_year_s1;
					month_nx = new_month_s1;
					day_nx   = new_day_s1;
					leap_nx  = new_leap_s1;
				end else begin
					status_nx = ST_BAD_LOAD;
				end
			end
			default: begin
				// unused code: hold the date
			end
		endcase
		doy_nx = days_before(month_nx) + DOY_W'(day_nx)
			+ DOY_W'((month_nx > FEBRUARY) && leap_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q    <= RESET_YEAR;
			month_q   <= JANUARY;
			day_q     <= FIRST_DAY;
			leap_q    <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				year_q  <= year_nx;
				month_q <= month_nx;
				day_q   <= day_nx;
				leap_q  <= leap_nx;
			end
			if (out_free) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_year_q   <= year_nx;
			res_month_q  <= month_nx;
			res_day_q    <= day_nx;
			res_doy_q    <= doy_nx;
			res_leap_q   <= leap_nx;
			res_status_q <= status_nx;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, res_leap_q, res_doy_q, res_day_q, res_month_q, res_year_q};
	assign m_tuser  = res_status_q;

	// Leap flag tracks the held year
	a_leap_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		leap_q == is_leap(year_q))
		else $error("leap flag does not match held year");

	// Held date is always a real calendar date
	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= JANUARY) && (month_q <= DECEMBER) && (day_q >= FIRST_DAY)
		&& (day_q <= month_len(month_q, leap_q)))
		else $error("held date is not a valid date");

	// A stalled result blocks any date update
	a_stall_holds_date: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(year_q) && $stable(month_q) && $stable(day_q)))
		else $error("date changed while result stalled");

endmodule

/* tb/tb_calendar_date_counter_core.sv */
// Self-checking testbench for calendar_date_counter_core: a queued stream driver,
// a date predictor updated on every accepted transaction and a result monitor.
// Depends on caldate_pkg and the core itself.
`timescale 1ns / 1ps

module tb_calendar_date_counter_core;
	import caldate_pkg::*;

	localparam int    MAX_YEAR    = 9999;
	localparam int    YEAR_SPAN   = 16383;
	localparam int    RANDOM_OPS  = 1500;
	localparam int    HOLD_AT     = 300;
	localparam int    HOLD_LEN    = 80;
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct {
		func_t  func;
		year_t  ny;
		month_t nm;
		day_t   nd;
		bit     drain_first;
	} date_cmd_t;

	typedef struct {
		year_t   year;
		month_t  month;
		day_t    day;
		doy_t    doy;
		logic    leap;
		status_t status;
	} date_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [FUNC_W-1:0]     s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	// Predicted date, mirroring the block's state
	year_t  cal_year;
	month_t cal_month;
	day_t   cal_day;

	date_cmd_t    pending_cmds[$];
	date_result_t expected_dates[$];
	date_cmd_t    next_cmd;
	date_result_t want;
	int           sent_count  = 0;
	int           error_count = 0;
	int           hold_cycles = 0;
	bit           hold_done   = 1'b0;
	bit           no_gaps;

	calendar_date_counter_core #(
		.MAX_YEAR(MAX_YEAR)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	assign no_gaps = (sent_count >= 700) && (sent_count < 1000);

	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in_month(input int m, input int y);
		int n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11:           n = 30;
			FEBRUARY:              n = leap_year(y) ? 29 : 28;
			default:               n = 0;
		endcase
		return n;
	endfunction

	function automatic int ordinal_of(input int m, input int d, input int y);
		int n;
		n = d;
		for (int k = 1; k < m; k++)
			n += days_in_month(k, y);
		return n;
	endfunction

	// Apply one operation to the predicted date and return the result it gives
	function automatic date_result_t apply_date_op(input func_t op, input year_t ny,
			input month_t nm, input day_t nd);
		date_result_t r;
		r.status = ST_OK;
		case (op)
			FUNC_ADVANCE: begin
				if (cal_month == DECEMBER && cal_day == LAST_DAY) begin
					if (cal_year >= MAX_YEAR) begin
						r.status = ST_RANGE;
					end else begin
						cal_year  = cal_year + 1'b1;
						cal_month = JANUARY;
						cal_day   = FIRST_DAY;
					end
				end else if (cal_day >= days_in_month(cal_month, cal_year)) begin
					cal_month = cal_month + 1'b1;
					cal_day   = FIRST_DAY;
				end else begin
					cal_day = cal_day + 1'b1;
				end
			end
			FUNC_RETREAT: begin
				if (cal_month == JANUARY && cal_day == FIRST_DAY) begin
					if (cal_year == 0) begin
						r.status = ST_RANGE;
					end else begin
						cal_year  = cal_year - 1'b1;
						cal_month = DECEMBER;
						cal_day   = LAST_DAY;
					end
				end else if (cal_day <= FIRST_DAY) begin
					cal_month = cal_month - 1'b1;
					cal_day   = day_t'(days_in_month(cal_month, cal_year));
				end else begin
					cal_day = cal_day - 1'b1;
				end
			end
			FUNC_LOAD: begin
				if (nm >= JANUARY && nm <= DECEMBER && nd >= FIRST_DAY &&
						nd <= days_in_month(nm, ny) && ny <= MAX_YEAR) begin
					cal_year  = ny;
					cal_month = nm;
					cal_day   = nd;
				end else begin
					r.status = ST_BAD_LOAD;
				end
			end
			default: ;
		endcase
		r.year  = cal_year;
		r.month = cal_month;
		r.day   = cal_day;
		r.doy   = doy_t'(ordinal_of(cal_month, cal_day, cal_year));
		r.leap  = leap_year(cal_year);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		error_count++;
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	task automatic push_op(input func_t f, input int y, input int m, input int d,
			input bit drain);
		date_cmd_t c;
		c.func        = f;
		c.ny          = year_t'(y);
		c.nm          = month_t'(m);
		c.nd          = day_t'(d);
		c.drain_first = drain;
		pending_cmds.push_back(c);
	endtask

	// Sender: predict on every accepted transaction, then offer the next command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_dates.push_back(apply_date_op(s_tuser, s_tdata[13:0],
					s_tdata[17:14], s_tdata[22:18]));
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() > 0 && (no_gaps || $urandom_range(99) >= 35) &&
						(!pending_cmds[0].drain_first || expected_dates.size() == 0)) begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, next_cmd.nd, next_cmd.nm, next_cmd.ny};
					s_tuser  <= next_cmd.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off to fill the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (!hold_done && sent_count >= HOLD_AT) begin
			m_tready    <= 1'b0;
			hold_cycles <= HOLD_LEN;
			hold_done   <= 1'b1;
		end else if (hold_cycles != 0) begin
			m_tready    <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= no_gaps || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dates.size() == 0) begin
				report_mismatch("unexpected result, year", m_tdata[13:0], 0);
			end else begin
				want = expected_dates.pop_front();
				if (m_tdata[13:0] !== want.year)
					report_mismatch("year", m_tdata[13:0], want.year);
				if (m_tdata[17:14] !== want.month)
					report_mismatch("month", m_tdata[17:14], want.month);
				if (m_tdata[22:18] !== want.day)
					report_mismatch("day", m_tdata[22:18], want.day);
				if (m_tdata[31:23] !== want.doy)
					report_mismatch("day_of_year", m_tdata[31:23], want.doy);
				if (m_tdata[32] !== want.leap)
					report_mismatch("leap_year", m_tdata[32], want.leap);
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
			end
		end
	end

	initial begin
		int queued;
		int r;
		int sel;
		int y;
		int m;
		int d;
		int len;
		int run;
		int dir;

		cal_year  = RESET_YEAR;
		cal_month = JANUARY;
		cal_day   = FIRST_DAY;

		// Directed: reset date, rollovers, leap rule, range limits, bad loads
		push_op(FUNC_ADVANCE, 0, 0, 0, 1'b0);
		push_op(FUNC_RETREAT, 0, 0, 0, 1'b0);
		push_op(FUNC_RETREAT, 0, 0, 0, 1'b0);
		push_op(FUNC_ADVANCE, YEAR_SPAN, 15, 31, 1'b0);
		push_op(FUNC_UNUSED, 1234, 7, 9, 1'b0);
		push_op(FUNC_LOAD, 2000, 2, 29, 1'b0);
		push_op(FUNC_ADVANCE, 0, 0, 0, 1'b0);
		push_op(FUNC_RETREAT, 0, 0, 0, 1'b0);
		push_op(FUNC_LOAD, 1900, 2, 29, 1'b0);
		push_op(FUNC_LOAD, 1900, 2, 28, 1'b0);
		push_op(FUNC_ADVANCE, 0, 0, 0, 1'b0);
		push_op(FUNC_LOAD, MAX_YEAR, 12, 31, 1'b0);
		push_op(FUNC_ADVANCE, 0, 0, 0, 1'b0);
		push_op(FUNC_LOAD, MAX_YEAR + 1, 1, 1, 1'b0);
		push_op(FUNC_LOAD, YEAR_SPAN, 15, 31, 1'b0);
		push_op(FUNC_LOAD, 0, 1, 1, 1'b0);
		push_op(FUNC_RETREAT, 0, 0, 0, 1'b0);
		push_op(FUNC_LOAD, 0, 2, 29, 1'b0);
		push_op(FUNC_LOAD, 2023, 0, 10, 1'b0);
		push_op(FUNC_LOAD, 2023, 13, 10, 1'b0);
		push_op(FUNC_LOAD, 2023, 4, 0, 1'b0);
		push_op(FUNC_LOAD, 2023, 4, 31, 1'b0);
		push_op(FUNC_LOAD, 2023, 12, 31, 1'b0);
		push_op(FUNC_ADVANCE, 0, 0, 0, 1'b0);
		push_op(FUNC_LOAD, 2024, 12, 31, 1'b0);

		// Random: mostly a checked load followed by a run of steps, some noise
		queued = 0;
		while (queued < RANDOM_OPS) begin
			r = $urandom_range(99);
			if (r < 70) begin
				sel = $urandom_range(9);
				case (sel)
					0:       y = 0;
					1:       y = MAX_YEAR;
					2:       y = MAX_YEAR - 1;
					3:       y = 100 * $urandom_range(99);
					4:       y = 400 * $urandom_range(24);
					5:       y = 4 * $urandom_range(2499);
					default: y = $urandom_range(MAX_YEAR);
				endcase
				m = $urandom_range(1, 12);
				if (sel <= 2 && $urandom_range(1))
					m = $urandom_range(1) ? 1 : 12;
				len = days_in_month(m, y);
				case ($urandom_range(3))
					0:       d = len;
					1:       d = 1;
					2:       d = len - $urandom_range(1);
					default: d = $urandom_range(1, len);
				endcase
				push_op(FUNC_LOAD, y, m, d, queued == 0 || $urandom_range(99) < 3);
				queued++;
				run = $urandom_range(1, 24);
				dir = $urandom_range(2);
				for (int k = 0; k < run; k++) begin
					push_op(dir == 0 ? FUNC_ADVANCE :
						dir == 1 ? FUNC_RETREAT :
						($urandom_range(1) ? FUNC_ADVANCE : FUNC_RETREAT),
						$urandom_range(YEAR_SPAN), $urandom_range(15),
						$urandom_range(31), 1'b0);
					queued++;
				end
			end else if (r < 85) begin
				push_op(func_t'($urandom_range(3)), $urandom_range(YEAR_SPAN),
					$urandom_range(15), $urandom_range(31), 1'b0);
				queued++;
			end else begin
				// Broken load: one field out of range
				y   = $urandom_range(MAX_YEAR);
				m   = $urandom_range(1, 12);
				len = days_in_month(m, y);
				d   = $urandom_range(1, len);
				case ($urandom_range(3))
					0:       m = $urandom_range(1) ? 0 : $urandom_range(13, 15);
					1:       d = 0;
					2:       d = (len == 31) ? 0 : $urandom_range(len + 1, 31);
					default: y = $urandom_range(MAX_YEAR + 1, YEAR_SPAN);
				endcase
				push_op(FUNC_LOAD, y, m, d, 1'b0);
				queued++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_dates.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
